/* rtl/core/bslp_pkg.sv */
// Package for the beat-sliced loop player: sizes, codes and channel payload types.
// Used by bslp_div and beat_slice_loop_player_unit; depends on nothing.
package bslp_pkg;

	localparam int unsigned SAMPLE_DEPTH = 65536;
	localparam int unsigned MAX_PARTS    = 16;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned START_W  = 16;
	localparam int unsigned CLOCK_W  = 32;
	localparam int unsigned CFG_W    = 17;
	localparam int unsigned TOTAL_W  = 5;

	localparam int unsigned ADDR_W = $clog2(SAMPLE_DEPTH);
	localparam int unsigned CMP_W  =
		($clog2(SAMPLE_DEPTH + 1) > 18) ? $clog2(SAMPLE_DEPTH + 1) : 18;
	localparam int unsigned IDX_W  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int unsigned PCNT_W = $clog2(MAX_PARTS + 1);

	// radix-4 restoring divider, two quotient bits per cycle
	localparam int unsigned DIV_W     = CLOCK_W;
	localparam int unsigned DEN_W     = CFG_W;
	localparam int unsigned DIV_STEPS = DIV_W / 2;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_PLAY   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic {
		REG_BEAT_LENGTH  = 1'b0,
		REG_SAMPLE_COUNT = 1'b1
	} reg_index_t;

	typedef struct packed {
		kind_t                      kind;
		logic [15:0]                sample_address;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [START_W-1:0]         part_start;
		logic [CLOCK_W-1:0]         clock_index;
		logic                       last_of_block;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		status_t                    status;
		logic [TOTAL_W-1:0]         part_total;
		logic                       last_in_block;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DEN_W-1:0] remainder;
	} div_rsp_t;

endpackage

/* rtl/core/bslp_div.sv */
// Iterative unsigned divider, two quotient bits per cycle, done pulse when finished.
// Depends on bslp_pkg (widths and request/response structs).
module bslp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bslp_pkg::div_req_t req,
	output bslp_pkg::div_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [bslp_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [bslp_pkg::DIV_W-1:0]          quo_q;
	logic [bslp_pkg::DEN_W-1:0]          rem_q;
	logic [bslp_pkg::DEN_W-1:0]          den_q;
	logic [bslp_pkg::DEN_W:0]            t0;
	logic [bslp_pkg::DEN_W:0]            t1;
	logic [bslp_pkg::DEN_W-1:0]          r0;
	logic [bslp_pkg::DEN_W-1:0]          r1;
	logic                                g0;
	logic                                g1;

	always_comb begin
		t0 = {rem_q, quo_q[bslp_pkg::DIV_W-1]};
		g0 = t0 >= {1'b0, den_q};
		r0 = g0 ? bslp_pkg::DEN_W'(t0 - {1'b0, den_q}) : t0[bslp_pkg::DEN_W-1:0];
		t1 = {r0, quo_q[bslp_pkg::DIV_W-2]};
		g1 = t1 >= {1'b0, den_q};
		r1 = g1 ? bslp_pkg::DEN_W'(t1 - {1'b0, den_q}) : t1[bslp_pkg::DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + bslp_pkg::DIV_CNT_W'(1);
				if (cnt_q == bslp_pkg::DIV_CNT_W'(bslp_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bslp_pkg::DIV_W-3:0], g0, g1};
			rem_q <= r1;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

	a_keep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start
			&& cnt_q != bslp_pkg::DIV_CNT_W'(bslp_pkg::DIV_STEPS - 1) |=> busy_q)
		else $error("divider stopped early");

endmodule

/* rtl/core/beat_slice_loop_player_unit.sv */
// Beat-sliced loop player: sample memory, sorted part start table, play sequencer.
// Depends on bslp_pkg and bslp_div.
//
//  channel | direction | handshake               | payload
//  in      | to block  | in_valid / in_ready     | in_item  (bslp_pkg::in_item_t)
//  out     | from block| out_valid / out_ready   | out_item (bslp_pkg::out_item_t)
//  cfg     | to block  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A write goes straight to output; add/delete pass an edit state; a play (unless the
// table is empty) makes two passes through the shared divider (clock / beat_length, then
// quotient mod part count), two table reads and, unless silent, one sample memory read.
// Reset leaves one part start (0), beat_length 1, sample_count 0; the sample
// memory is not cleared. A finished transaction waits in the output register,
// so the next item is taken while out_ready is low.
module beat_slice_loop_player_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bslp_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bslp_pkg::out_item_t          out_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  bslp_pkg::reg_index_t         cfg_index,
	input  logic [bslp_pkg::CFG_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDIT,
		S_DIV1,
		S_DIV2,
		S_RD0,
		S_RD1,
		S_MEM,
		S_EMIT
	} state_t;

	state_t                                state_q;
	bslp_pkg::in_item_t                    item_q;
	bslp_pkg::out_item_t                   res_q;
	bslp_pkg::out_item_t                   out_q;
	logic                                  out_valid_q;
	logic [bslp_pkg::CFG_W-1:0]            beat_len_q;
	logic [bslp_pkg::CFG_W-1:0]            smp_cnt_q;
	logic [bslp_pkg::START_W-1:0]          tab_q [bslp_pkg::MAX_PARTS];
	logic [bslp_pkg::PCNT_W-1:0]           count_q;
	logic [bslp_pkg::DEN_W-1:0]            offs_q;
	logic [bslp_pkg::IDX_W-1:0]            rd_idx_q;
	logic                                  last_beat_q;
	logic [bslp_pkg::START_W-1:0]          base_q;
	logic signed [bslp_pkg::SAMPLE_W-1:0]  rdata_q;
	logic signed [bslp_pkg::SAMPLE_W-1:0]  sample_mem [bslp_pkg::SAMPLE_DEPTH];

	logic                                  in_acc;
	logic                                  emit_go;
	bslp_pkg::out_item_t                   first_res;
	logic [bslp_pkg::MAX_PARTS-1:0]        ent_valid;
	logic [bslp_pkg::MAX_PARTS-1:0]        eq_v;
	logic [bslp_pkg::MAX_PARTS-1:0]        lt_v;
	logic [bslp_pkg::MAX_PARTS-1:0]        ge_v;
	logic [bslp_pkg::MAX_PARTS-1:0]        sort_bad;
	logic [bslp_pkg::START_W-1:0]          ins_tab [bslp_pkg::MAX_PARTS];
	logic [bslp_pkg::START_W-1:0]          del_tab [bslp_pkg::MAX_PARTS];
	logic                                  has_match;
	logic                                  tab_full;
	logic [bslp_pkg::START_W-1:0]          rd_val;
	logic [bslp_pkg::CMP_W-1:0]            clamp_cnt;
	logic [bslp_pkg::CMP_W-1:0]            limit;
	logic [bslp_pkg::CMP_W-1:0]            pos;
	logic                                  hit;
	logic                                  mem_we;
	logic                                  mem_re;
	logic [bslp_pkg::CMP_W-1:0]            waddr_ext;
	logic [bslp_pkg::DEN_W-1:0]            beat_full;
	bslp_pkg::div_req_t                    div_req;
	bslp_pkg::div_rsp_t                    div_rsp;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// table edits: each entry looks only at itself and its neighbors
	generate
		for (genvar gi = 0; gi < bslp_pkg::MAX_PARTS; gi++) begin : g_ent
			assign ent_valid[gi] = bslp_pkg::PCNT_W'(gi) < count_q;
			assign eq_v[gi] = ent_valid[gi] && (tab_q[gi] == item_q.part_start);
			assign lt_v[gi] = ent_valid[gi] && (tab_q[gi] < item_q.part_start);
			assign ge_v[gi] = ent_valid[gi] && (tab_q[gi] >= item_q.part_start);
			if (gi == 0) begin : g_first
				assign ins_tab[gi]  = lt_v[gi] ? tab_q[gi] : item_q.part_start;
				assign sort_bad[gi] = 1'b0;
			end else begin : g_rest
				assign ins_tab[gi]  = lt_v[gi] ? tab_q[gi] :
					(lt_v[gi-1] ? item_q.part_start : tab_q[gi-1]);
				assign sort_bad[gi] = ent_valid[gi] && (tab_q[gi] <= tab_q[gi-1]);
			end
			if (gi == bslp_pkg::MAX_PARTS - 1) begin : g_tail
				assign del_tab[gi] = tab_q[gi];
			end else begin : g_body
				assign del_tab[gi] = ge_v[gi] ? tab_q[gi+1] : tab_q[gi];
			end
		end
	endgenerate

	assign has_match = |eq_v;
	assign tab_full  = (count_q == bslp_pkg::PCNT_W'(bslp_pkg::MAX_PARTS));

	// play position and limit
	assign rd_val    = tab_q[rd_idx_q];
	assign clamp_cnt = (bslp_pkg::CMP_W'(smp_cnt_q) > bslp_pkg::CMP_W'(bslp_pkg::SAMPLE_DEPTH))
		? bslp_pkg::CMP_W'(bslp_pkg::SAMPLE_DEPTH) : bslp_pkg::CMP_W'(smp_cnt_q);
	assign limit     = last_beat_q ? clamp_cnt : bslp_pkg::CMP_W'(rd_val);
	assign pos       = bslp_pkg::CMP_W'(base_q) + bslp_pkg::CMP_W'(offs_q);
	assign hit       = (pos < limit) && (pos < bslp_pkg::CMP_W'(bslp_pkg::SAMPLE_DEPTH));
	assign mem_re    = (state_q == S_RD1) && hit;

	assign waddr_ext = bslp_pkg::CMP_W'(in_item.sample_address);
	assign mem_we    = in_acc && (in_item.kind == bslp_pkg::KIND_WRITE)
		&& (waddr_ext < bslp_pkg::CMP_W'(bslp_pkg::SAMPLE_DEPTH));

	assign beat_full = div_rsp.remainder;

	always_comb begin
		first_res = '{sample_out: '0, status: bslp_pkg::ST_OK,
			part_total: bslp_pkg::TOTAL_W'(count_q), last_in_block: 1'b0};
		if (in_item.kind == bslp_pkg::KIND_PLAY) begin
			first_res.last_in_block = in_item.last_of_block;
			if (count_q == '0) begin
				first_res.status = bslp_pkg::ST_EMPTY;
			end
		end
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = in_item.clock_index;
		div_req.divisor  = (beat_len_q == '0) ? bslp_pkg::DEN_W'(1) : beat_len_q;
		if (in_acc && in_item.kind == bslp_pkg::KIND_PLAY && count_q != '0) begin
			div_req.start = 1'b1;
		end else if (state_q == S_DIV1 && div_rsp.done) begin
			div_req.start    = 1'b1;
			div_req.dividend = div_rsp.quotient;
			div_req.divisor  = bslp_pkg::DEN_W'(count_q);
		end
	end

	bslp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			beat_len_q  <= bslp_pkg::CFG_W'(1);
			smp_cnt_q   <= '0;
			count_q     <= bslp_pkg::PCNT_W'(1);
			offs_q      <= '0;
			rd_idx_q    <= '0;
			last_beat_q <= 1'b0;
			base_q      <= '0;
			for (int i = 0; i < bslp_pkg::MAX_PARTS; i++) begin
				tab_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					bslp_pkg::REG_BEAT_LENGTH:  beat_len_q <= cfg_data;
					bslp_pkg::REG_SAMPLE_COUNT: smp_cnt_q  <= cfg_data;
				endcase
			end
			if (emit_go) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						item_q <= in_item;
						res_q  <= first_res;
						unique case (in_item.kind)
							bslp_pkg::KIND_WRITE: state_q <= S_EMIT;
							bslp_pkg::KIND_ADD, bslp_pkg::KIND_DELETE: state_q <= S_EDIT;
							bslp_pkg::KIND_PLAY: begin
								if (count_q == '0) begin
									state_q <= S_EMIT;
								end else begin
									state_q <= S_DIV1;
								end
							end
						endcase
					end
				end
				S_EDIT: begin
					if (item_q.kind == bslp_pkg::KIND_ADD) begin
						priority if (has_match) begin
							res_q.status <= bslp_pkg::ST_DUPLICATE;
						end else if (tab_full) begin
							res_q.status <= bslp_pkg::ST_FULL;
						end else begin
							tab_q            <= ins_tab;
							count_q          <= count_q + bslp_pkg::PCNT_W'(1);
							res_q.part_total <= bslp_pkg::TOTAL_W'(count_q + bslp_pkg::PCNT_W'(1));
						end
					end else begin
						if (has_match) begin
							tab_q            <= del_tab;
							count_q          <= count_q - bslp_pkg::PCNT_W'(1);
							res_q.part_total <= bslp_pkg::TOTAL_W'(count_q - bslp_pkg::PCNT_W'(1));
						end else begin
							res_q.status <= bslp_pkg::ST_NOT_FOUND;
						end
					end
					state_q <= S_EMIT;
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						offs_q  <= div_rsp.remainder;
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						rd_idx_q    <= beat_full[bslp_pkg::IDX_W-1:0];
						last_beat_q <= (bslp_pkg::DEN_W'(beat_full + bslp_pkg::DEN_W'(1))
							== bslp_pkg::DEN_W'(count_q));
						state_q     <= S_RD0;
					end
				end
				S_RD0: begin
					base_q   <= rd_val;
					rd_idx_q <= rd_idx_q + bslp_pkg::IDX_W'(1);
					state_q  <= S_RD1;
				end
				S_RD1: begin
					state_q <= hit ? S_MEM : S_EMIT;
				end
				S_MEM: begin
					res_q.sample_out <= rdata_q;
					state_q          <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sample_mem[waddr_ext[bslp_pkg::ADDR_W-1:0]] <= in_item.sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= sample_mem[pos[bslp_pkg::ADDR_W-1:0]];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bslp_pkg::PCNT_W'(bslp_pkg::MAX_PARTS))
		else $error("part count above table size");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		sort_bad == '0)
		else $error("part table not strictly ascending");

	a_empty_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == bslp_pkg::ST_EMPTY |-> out_q.sample_out == '0)
		else $error("empty table transaction carries a sample");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider finished outside a divide state");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for beat_slice_loop_player_unit: directed and random write, add, delete and play
// transactions, each result checked by a scoreboard class that predicts the player's behavior.
// Depends on bslp_pkg and the player RTL.

module tb;
	import bslp_pkg::*;

	localparam int unsigned LIMIT = 1000000;

	class slice_scoreboard;
		logic [SAMPLE_W-1:0] samples [SAMPLE_DEPTH];
		bit                  written [SAMPLE_DEPTH];
		logic [START_W-1:0]  starts [MAX_PARTS];
		int unsigned         nparts;
		logic [CFG_W-1:0]    beat_len;
		logic [CFG_W-1:0]    valid_len;
		out_item_t           awaited [$];
		int                  errors;

		function new();
			foreach (starts[i]) starts[i] = '0;
			nparts    = 1;
			beat_len  = 1;
			valid_len = 0;
			errors    = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [CFG_W-1:0] val);
			if (idx == REG_BEAT_LENGTH) begin
				beat_len = val;
			end else begin
				valid_len = val;
			end
		endfunction

		// memory position a play reads, -1 for silence
		function int play_position(logic [CLOCK_W-1:0] clk_idx);
			int unsigned bl, beat, pos, lim;
			if (nparts == 0) return -1;
			bl   = (beat_len == 0) ? 1 : beat_len;
			beat = (clk_idx / bl) % nparts;
			pos  = starts[beat] + clk_idx % bl;
			if (beat + 1 < nparts) begin
				lim = starts[beat + 1];
			end else begin
				lim = (valid_len > SAMPLE_DEPTH) ? SAMPLE_DEPTH : valid_len;
			end
			if (pos >= lim || pos >= SAMPLE_DEPTH) return -1;
			return pos;
		endfunction

		function status_t add_start(logic [START_W-1:0] v);
			int at;
			at = nparts;
			for (int i = 0; i < nparts; i++) begin
				if (starts[i] == v) return ST_DUPLICATE;
			end
			if (nparts >= MAX_PARTS) return ST_FULL;
			for (int i = 0; i < nparts; i++) begin
				if (starts[i] > v) begin
					at = i;
					break;
				end
			end
			for (int i = nparts; i > at; i--) starts[i] = starts[i - 1];
			starts[at] = v;
			nparts++;
			return ST_OK;
		endfunction

		function status_t del_start(logic [START_W-1:0] v);
			for (int i = 0; i < nparts; i++) begin
				if (starts[i] == v) begin
					for (int j = i; j + 1 < nparts; j++) starts[j] = starts[j + 1];
					nparts--;
					return ST_OK;
				end
			end
			return ST_NOT_FOUND;
		endfunction

		function void note_item(in_item_t it);
			out_item_t want;
			int        pos;
			want = '0;
			case (it.kind)
				KIND_WRITE: begin
					samples[it.sample_address] = it.sample_in;
					written[it.sample_address] = 1'b1;
				end
				KIND_ADD: want.status = add_start(it.part_start);
				KIND_DELETE: want.status = del_start(it.part_start);
				default: begin
					pos = play_position(it.clock_index);
					if (nparts == 0) begin
						want.status = ST_EMPTY;
					end else if (pos >= 0) begin
						want.sample_out = samples[pos];
					end
					want.last_in_block = it.last_of_block;
				end
			endcase
			want.part_total = TOTAL_W'(nparts);
			awaited = {awaited, want};
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare("sample_out", want.sample_out, got.sample_out);
			compare("status", 16'(want.status), 16'(got.status));
			compare("part_total", 16'(want.part_total), 16'(got.part_total));
			compare("last_in_block", 16'(want.last_in_block), 16'(got.last_in_block));
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	in_item_t         in_item   = '0;
	logic             out_ready = 1'b0;
	logic             cfg_valid = 1'b0;
	reg_index_t       cfg_index = REG_BEAT_LENGTH;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             in_ready;
	logic             out_valid;
	logic             cfg_ready;
	out_item_t        out_item;

	slice_scoreboard    sb;
	int unsigned        cycles     = 0;
	int unsigned        stall_left = 0;
	bit                 calm       = 1'b0;
	bit                 in_idle_on = 1'b1;
	int unsigned        span       = 64;
	logic [CLOCK_W-1:0] play_clock = '0;

	always #4 clk = ~clk;

	beat_slice_loop_player_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_item);
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && arst_n && (cycles / 400) % 3 != 2 && $urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send(in_item_t it);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
		if (!calm && in_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// plays that would hit a never-written entry get that entry written first
	task automatic issue(kind_t k, logic [15:0] addr, logic [15:0] smp, logic [15:0] ps,
			logic [CLOCK_W-1:0] ck, logic last);
		in_item_t it;
		in_item_t fill;
		int       pos;
		it.kind           = k;
		it.sample_address = addr;
		it.sample_in      = smp;
		it.part_start     = ps;
		it.clock_index    = ck;
		it.last_of_block  = last;
		if (k == KIND_PLAY) begin
			pos = sb.play_position(ck);
			if (pos >= 0 && !sb.written[pos]) begin
				fill                = it;
				fill.kind           = KIND_WRITE;
				fill.sample_address = 16'(pos);
				fill.sample_in      = 16'($urandom);
				send(fill);
			end
		end
		send(it);
	endtask

	task automatic cfg_write(reg_index_t idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic set_regs(logic [CFG_W-1:0] bl, logic [CFG_W-1:0] cnt);
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		cfg_write(REG_BEAT_LENGTH, bl);
		cfg_write(REG_SAMPLE_COUNT, cnt);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(int unsigned add_pct, int unsigned del_pct);
		int unsigned        r, bl, hi;
		longint unsigned    lr;
		logic [15:0]        ps, addr;
		logic [CLOCK_W-1:0] ck;
		r  = $urandom_range(0, 99);
		bl = (sb.beat_len == 0) ? 1 : sb.beat_len;
		if (r < add_pct) begin
			if ($urandom_range(0, 4) == 0) ps = 16'($urandom);
			else ps = 16'($urandom_range(0, span - 1));
			issue(KIND_ADD, 16'($urandom), 16'($urandom), ps, $urandom, 1'($urandom));
		end else if (r < add_pct + del_pct) begin
			if (sb.nparts > 0 && $urandom_range(0, 9) < 7)
				ps = sb.starts[$urandom_range(0, sb.nparts - 1)];
			else
				ps = 16'($urandom_range(0, span - 1));
			issue(KIND_DELETE, 16'($urandom), 16'($urandom), ps, $urandom, 1'($urandom));
		end else if (r < add_pct + del_pct + 25) begin
			hi = span + bl;
			if (hi > 65535) hi = 65535;
			if ($urandom_range(0, 4) == 0) addr = 16'($urandom);
			else addr = 16'($urandom_range(0, hi));
			issue(KIND_WRITE, addr, 16'($urandom), 16'($urandom), $urandom, 1'($urandom));
		end else begin
			case ($urandom_range(0, 4))
				0: ck = $urandom;
				1, 2: begin
					play_clock = play_clock + CLOCK_W'(1);
					ck = play_clock;
				end
				default: begin
					lr = longint'(bl) * (sb.nparts + 1) * 2;
					if (lr > 64'hFFFF_FFFF) lr = 64'hFFFF_FFFF;
					ck = $urandom_range(0, 32'(lr));
				end
			endcase
			issue(KIND_PLAY, 16'($urandom), 16'($urandom), 16'($urandom), ck,
				$urandom_range(0, 7) == 0);
		end
	endtask

	task automatic run_phase(logic [CFG_W-1:0] bl, logic [CFG_W-1:0] cnt, int unsigned sp,
			int unsigned n, int unsigned add_pct, int unsigned del_pct);
		set_regs(bl, cnt);
		span       = sp;
		play_clock = $urandom_range(0, 1000);
		for (int i = 0; i < n; i++) begin
			in_idle_on = ((i / 40) % 3 != 2);
			random_item(add_pct, del_pct);
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero beat length counts as one
		set_regs(17'd0, 17'd8);
		issue(KIND_WRITE, 16'd0, 16'h7FFF, 16'h0000, 32'd0, 1'b0);
		issue(KIND_WRITE, 16'd1, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		issue(KIND_WRITE, 16'd3, 16'hFFFF, 16'd0, 32'd0, 1'b0);
		issue(KIND_WRITE, 16'd2, 16'h0000, 16'd0, 32'd0, 1'b0);
		issue(KIND_WRITE, 16'hFFFF, 16'h5A5A, 16'd0, 32'd0, 1'b0);
		issue(KIND_PLAY, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0);
		issue(KIND_PLAY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		// empty table, missing start, duplicate
		issue(KIND_DELETE, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1);
		issue(KIND_PLAY, 16'd0, 16'd0, 16'd0, 32'd5, 1'b1);
		issue(KIND_DELETE, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0);
		issue(KIND_ADD, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0);
		issue(KIND_ADD, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0);
		issue(KIND_ADD, 16'd0, 16'd0, 16'd4, 32'd0, 1'b0);
		set_regs(17'd3, 17'd8);
		issue(KIND_PLAY, 16'd0, 16'd0, 16'd0, 32'd2, 1'b0);
		issue(KIND_PLAY, 16'd0, 16'd0, 16'd0, 32'd4, 1'b0);
		// slice runs into the next start, last slice runs into the end of the buffer
		set_regs(17'd5, 17'd8);
		issue(KIND_PLAY, 16'd0, 16'd0, 16'd0, 32'd4, 1'b0);
		issue(KIND_PLAY, 16'd0, 16'd0, 16'd0, 32'd9, 1'b1);
		// oversized sample count and positions past the memory
		set_regs(17'h1FFFF, 17'h1FFFF);
		issue(KIND_DELETE, 16'd0, 16'd0, 16'd4, 32'd0, 1'b0);
		issue(KIND_ADD, 16'd0, 16'd0, 16'hFFFF, 32'd0, 1'b0);
		issue(KIND_PLAY, 16'd0, 16'd0, 16'd0, 32'd131075, 1'b0);
		issue(KIND_PLAY, 16'd0, 16'd0, 16'd0, 32'd131071, 1'b0);
		issue(KIND_PLAY, 16'd0, 16'd0, 16'd0, 32'd65535, 1'b1);

		run_phase(17'd1, 17'd64, 64, 150, 30, 8);
		run_phase(17'd8, 17'd200, 256, 150, 20, 10);
		run_phase(17'd0, 17'h1FFFF, 1024, 150, 15, 10);
		run_phase(17'd65536, 17'd65536, 65536, 120, 15, 10);
		run_phase(17'h1FFFF, 17'd300, 65536, 120, 15, 10);
		run_phase(17'($urandom_range(1, 64)), 17'($urandom_range(0, 512)), 512, 150, 15, 12);
		run_phase(17'd3, 17'd0, 32, 120, 8, 25);
		run_phase(17'($urandom), 17'($urandom), 65536, 150, 15, 10);
		calm = 1'b1;
		run_phase(17'd5, 17'd100, 128, 150, 20, 10);

		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
